@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// boolean condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ sv/sitda_pkg.sv @@
// types and constants for the signed integer to decimal ascii converter
// no dependencies
package sitda_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 32;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_AW        = 3;
  localparam int unsigned MINW_W        = 6;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned NUM_DIGITS    = 10;
  localparam int unsigned DIG_W         = 4;
  localparam int unsigned NDIG_W        = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_FILL  = 8'h5F;

  // floor(n / 10) = (n * RECIP10) >> RECIP_SHIFT for any 32-bit n
  localparam logic [VAL_W-1:0] RECIP10     = 32'hCCCCCCCD;
  localparam int unsigned      RECIP_SHIFT = 35;

  localparam logic [CFG_AW-3:0] REG_MIN_WIDTH = '0;

  typedef struct packed {
    logic                           neg;
    logic [NDIG_W-1:0]              ndig;
    logic [NUM_DIGITS*DIG_W-1:0]    digits;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

  typedef struct packed {
    logic  empty;
    desc_t desc;
  } q_rd_t;

endpackage

@@ sv/sitda_front.sv @@
// front end: takes a value, splits its magnitude into decimal digits
// depends on sitda_pkg
module sitda_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sitda_pkg::VAL_W-1:0]  value_i,
  input  logic                                q_full_i,
  output sitda_pkg::q_wr_t                    q_wr_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  localparam int unsigned VW = sitda_pkg::VAL_W;
  localparam int unsigned DW = sitda_pkg::DIG_W;

  logic [1:0]                                       state_q, state_d;
  logic [sitda_pkg::NDIG_W-1:0]                     cnt_q, cnt_d;
  logic [VW-1:0]                                    mag_q;
  logic                                             neg_q;
  logic [sitda_pkg::NUM_DIGITS*DW-1:0]              digits_q;

  logic [VW-1:0]   raw;
  logic [2*VW-1:0] prod;
  logic [VW-1:0]   quot;
  logic [VW-1:0]   times10;
  logic [VW-1:0]   rem;
  logic            last_dig;
  logic            accept;

  assign raw      = value_i;
  assign accept   = push && (state_q == ST_IDLE);
  assign prod     = {{VW{1'b0}}, mag_q} * {{VW{1'b0}}, sitda_pkg::RECIP10};
  assign quot     = VW'(prod >> sitda_pkg::RECIP_SHIFT);
  assign times10  = (quot << 3) + (quot << 1);
  assign rem      = mag_q - times10;
  assign last_dig = (quot == '0) ||
                    (cnt_q == sitda_pkg::NDIG_W'(sitda_pkg::NUM_DIGITS - 1));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CONV;
          cnt_d   = '0;
        end
      end
      ST_CONV: begin
        cnt_d = cnt_q + 1'b1;
        if (last_dig) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      neg_q <= raw[VW-1];
      mag_q <= raw[VW-1] ? (VW'(0) - raw) : raw;
    end else if (state_q == ST_CONV) begin
      mag_q                          <= quot;
      digits_q[cnt_q*DW +: DW]       <= rem[DW-1:0];
    end
  end

  assign full               = (state_q != ST_IDLE);
  assign q_wr_o.push        = (state_q == ST_PUSH) && !q_full_i;
  assign q_wr_o.desc.neg    = neg_q;
  assign q_wr_o.desc.ndig   = cnt_q;
  assign q_wr_o.desc.digits = digits_q;

endmodule

@@ sv/sitda_fifo.sv @@
// short descriptor queue between front and back end
// depends on sitda_pkg
module sitda_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sitda_pkg::q_wr_t q_wr_i,
  output logic             full_o,
  input  logic             pop_i,
  output sitda_pkg::q_rd_t q_rd_o
);

  localparam int unsigned DEPTH = sitda_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sitda_pkg::desc_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;
  logic               do_wr, do_rd;

  assign full_o = (count_q == (PTR_W+1)'(DEPTH));
  assign do_wr  = q_wr_i.push && !full_o;
  assign do_rd  = pop_i && (count_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= q_wr_i.desc;
    end
  end

  assign q_rd_o.empty = (count_q == '0);
  assign q_rd_o.desc  = mem_q[rd_ptr_q];

endmodule

@@ sv/sitda_back.sv @@
// back end: emits fill, sign and digits one character per cycle while results are popped
// depends on sitda_pkg
module sitda_back #(
  parameter int unsigned MAX_WIDTH = sitda_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sitda_pkg::MINW_W-1:0]        min_width_i,
  input  sitda_pkg::q_rd_t                    q_rd_i,
  output logic                                q_pop_o,
  input  logic                                pop,
  output logic                                empty,
  output logic [sitda_pkg::CHAR_W-1:0]        out_char_o,
  output logic                                last_o
);

  localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW  = (WCW > sitda_pkg::MINW_W) ? WCW : sitda_pkg::MINW_W;
  localparam int unsigned DW  = sitda_pkg::DIG_W;

  logic                                  active_q;
  logic [WCW-1:0]                        fill_q;
  logic                                  sign_q;
  logic [sitda_pkg::NDIG_W-1:0]          idx_q;
  logic [sitda_pkg::NUM_DIGITS*DW-1:0]   digits_q;
  logic                                  ovalid_q;
  logic [sitda_pkg::CHAR_W-1:0]          ochar_q;
  logic                                  olast_q;

  logic                                  adv, load, emit, emit_last;
  logic [WCW-1:0]                        textlen, sat_w, fill_n;
  logic [DW-1:0]                         cur_dig;
  logic [sitda_pkg::CHAR_W-1:0]          next_char;

  assign adv     = !ovalid_q || pop;
  assign load    = !active_q && !q_rd_i.empty;
  assign emit    = active_q && adv;
  assign q_pop_o = load;

  assign textlen = WCW'(q_rd_i.desc.ndig) + WCW'(q_rd_i.desc.neg);
  assign sat_w   = (CW'(min_width_i) > CW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(min_width_i);
  assign fill_n  = (sat_w > textlen) ? (sat_w - textlen) : '0;

  assign cur_dig   = digits_q[idx_q*DW +: DW];
  assign emit_last = (fill_q == '0) && !sign_q && (idx_q == '0);

  always_comb begin
    if (fill_q != '0) begin
      next_char = sitda_pkg::CH_FILL;
    end else if (sign_q) begin
      next_char = sitda_pkg::CH_MINUS;
    end else begin
      next_char = sitda_pkg::CH_ZERO + sitda_pkg::CHAR_W'(cur_dig);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovalid_q <= 1'b0;
      fill_q   <= '0;
      sign_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (adv) begin
        ovalid_q <= active_q;
      end
      if (load) begin
        active_q <= 1'b1;
        fill_q   <= fill_n;
        sign_q   <= q_rd_i.desc.neg;
        idx_q    <= q_rd_i.desc.ndig - 1'b1;
      end else if (emit) begin
        if (fill_q != '0) begin
          fill_q <= fill_q - 1'b1;
        end else if (sign_q) begin
          sign_q <= 1'b0;
        end else if (emit_last) begin
          active_q <= 1'b0;
        end else begin
          idx_q <= idx_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      digits_q <= q_rd_i.desc.digits;
    end
    if (emit) begin
      ochar_q <= next_char;
      olast_q <= emit_last;
    end
  end

  assign empty      = !ovalid_q;
  assign out_char_o = ochar_q;
  assign last_o     = olast_q;

endmodule

@@ sv/signed_int_to_decimal_ascii_top.sv @@
// top level of the signed integer to decimal ascii converter
// depends on sitda_pkg, sitda_front, sitda_fifo, sitda_back
//
// channel   direction  handshake            payload
// input     in         push / full          value_i
// result    out        pop / empty          out_char_o, last_o
// config    in         apb psel/penable     min_width at byte address 0
//
// the front end takes one value at a time and extracts its decimal digits
// through the reciprocal multiplier; the back end loads a descriptor, then emits
// its characters in turn. a two-entry descriptor queue sits between them.
// reset is asynchronous, active low; min_width resets to zero.
// a stalled result holds on the ports until popped.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned MAX_WIDTH = sitda_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [sitda_pkg::VAL_W-1:0]  value_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [sitda_pkg::CHAR_W-1:0]        out_char_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sitda_pkg::CFG_AW-1:0]        paddr,
  input  logic [sitda_pkg::DATA_W-1:0]        pwdata,
  output logic [sitda_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [sitda_pkg::MINW_W-1:0] min_width_q;
  logic                         reg_sel;
  logic                         q_full;
  logic                         q_pop;
  sitda_pkg::q_wr_t             q_wr;
  sitda_pkg::q_rd_t             q_rd;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[sitda_pkg::CFG_AW-1:2] == sitda_pkg::REG_MIN_WIDTH);
  assign prdata  = reg_sel ? sitda_pkg::DATA_W'(min_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      min_width_q <= pwdata[sitda_pkg::MINW_W-1:0];
    end
  end

  sitda_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  sitda_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_wr_i (q_wr),
    .full_o (q_full),
    .pop_i  (q_pop),
    .q_rd_o (q_rd)
  );

  sitda_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_width_i (min_width_q),
    .q_rd_i      (q_rd),
    .q_pop_o     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/sitda_checker.sv @@
// port-level checker for the converter, bound to the top level
// depends on sitda_pkg and assert_macros.svh
`include "assert_macros.svh"

module sitda_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty,
  input logic                         pop,
  input logic [sitda_pkg::CHAR_W-1:0] out_char_o,
  input logic                         last_o
);

  logic is_digit;
  logic is_fill;
  logic is_minus;

  assign is_digit = (out_char_o >= sitda_pkg::CH_ZERO) && (out_char_o <= sitda_pkg::CH_NINE);
  assign is_fill  = (out_char_o == sitda_pkg::CH_FILL);
  assign is_minus = (out_char_o == sitda_pkg::CH_MINUS);

  `ASSERT_AT(a_stall_hold, clk_i, rst_ni, !empty && !pop |=> !empty && $stable(out_char_o) && $stable(last_o))
  `ASSERT_NEVER(a_char_set, clk_i, rst_ni, !empty && !(is_digit || is_fill || is_minus))
  `ASSERT_AT(a_last_on_digit, clk_i, rst_ni, !empty && last_o |-> is_digit)
  `ASSERT_AT(a_sign_then_digit, clk_i, rst_ni, !empty && pop && is_minus |=> !empty && is_digit)
  `ASSERT_AT(a_digit_run, clk_i, rst_ni, !empty && pop && is_digit && !last_o |=> !empty && is_digit)

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_sitda_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .last_o     (last_o)
);
